// ----- rtl/smad_pkg.sv -----
// ============================================================================
// smad_pkg
// Shared constants and types for the sliding median absolute deviation block.
// ============================================================================
package smad_pkg;
    localparam int MAX_WINDOW_DEF   = 64;
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int KW               = 7;
    localparam int COST_W           = 21;
    localparam logic [KW-1:0] WINDOW_RESET = 7'd8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REMOVE,
        ST_INSERT,
        ST_SUM
    } smad_state_t;

    typedef struct packed {
        logic remove;
        logic insert;
        logic clear;
    } smad_cell_ctl_t;
endpackage

// ----- rtl/smad_cell.sv -----
// ============================================================================
// smad_cell
// One sorted-row cell: removes or inserts a value by comparing with the key
// and its left neighbor's flags, taking data from a neighbor or the key.
// ============================================================================
module smad_cell
    import smad_pkg::*;
#(
    parameter int SW = SAMPLE_WIDTH_DEF
) (
    input  logic           aclk,
    input  smad_cell_ctl_t ctl,
    input  logic [SW-1:0]  key,
    input  logic [SW-1:0]  left_val,
    input  logic           left_match,
    input  logic           left_gt,
    input  logic [SW-1:0]  right_val,
    input  logic           occupied,
    output logic [SW-1:0]  val,
    output logic           match_out,
    output logic           gt_out
);
    logic [SW-1:0] val_reg;
    logic [SW-1:0] val_next;
    logic          my_match;
    logic          my_gt;

    assign my_match  = occupied && (val_reg == key);
    assign match_out = left_match || my_match;
    assign my_gt     = occupied && (val_reg > key);
    assign gt_out    = my_gt;
    assign val       = val_reg;

    always_comb begin
        val_next = val_reg;
        if (ctl.remove) begin
            if (match_out) val_next = right_val;
        end else if (ctl.insert) begin
            if (left_gt) val_next = left_val;
            else if (my_gt || !occupied) val_next = key;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end
endmodule

// ----- rtl/sliding_median_abs_deviation.sv -----
// ============================================================================
// sliding_median_abs_deviation
// Sliding-window median absolute deviation sum over a sorted cell row.
// ============================================================================
// Usage:
//   s_axis: one sample per transaction in s_axis_tdata.
//   m_axis: one cost per transaction once the window holds k samples.
//   cfg: write window_size (cfg_tdata, cfg_tvalid/cfg_tready) while idle;
//   a write empties the window.
// Sequence: a full-window item removes the oldest sample from the sorted
//   row, inserts the new one, then accumulates one cell per cycle through a
//   single adder and hands the cost to the output register once that
//   register is free. The next sample is taken only after that hand-over,
//   back in idle. While the window fills, an item skips the removal.
// Reset (aresetn low) empties the window and sets k to 8.
// A stalled receiver holds the cost in the output register; the next
// sample is taken, but its result waits until that register is free.
// ============================================================================
module sliding_median_abs_deviation
    import smad_pkg::*;
#(
    parameter int MAX_WINDOW   = MAX_WINDOW_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,   // sample
    input  logic        cfg_tvalid,
    output logic        cfg_tready,
    input  logic [7:0]  cfg_tdata,      // [6:0] window_size
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [20:0] cost
);
    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int SW = SAMPLE_WIDTH;

    smad_state_t    state_reg, state_next;
    logic [KW-1:0]  wsize_reg;
    logic [CW-1:0]  k_eff;
    logic [CW-1:0]  fill_reg, fill_next;
    logic [AW-1:0]  ptr_reg, ptr_next;
    logic [SW-1:0]  sample_reg;
    logic [SW-1:0]  ring [MAX_WINDOW];
    logic [SW-1:0]  old_reg;
    logic [CW-1:0]  idx_reg, idx_next;
    logic [COST_W-1:0] acc_reg, acc_next;
    logic           out_valid_reg;
    logic [COST_W-1:0] out_data_reg;
    logic           done;
    smad_cell_ctl_t ctl;
    logic [SW-1:0]  key;
    logic [SW-1:0]  vals  [MAX_WINDOW];
    logic           match [MAX_WINDOW];
    logic           gts   [MAX_WINDOW];
    logic [SW-1:0]  cur;
    logic [CW-1:0]  half;
    logic [SW-1:0]  in_s;

    assign in_s = s_axis_tdata[SW-1:0];

    always_comb begin
        if (wsize_reg == '0) k_eff = CW'(1);
        else if ({{(32-KW){1'b0}}, wsize_reg} > MAX_WINDOW) k_eff = CW'(MAX_WINDOW);
        else k_eff = CW'(wsize_reg);
    end
    assign half = CW'((k_eff + CW'(1)) >> 1);

    assign s_axis_tready = (state_reg == ST_IDLE) && !cfg_tvalid;
    assign cfg_tready    = (state_reg == ST_IDLE);
    assign key = (state_reg == ST_REMOVE) ? old_reg : sample_reg;
    assign ctl.remove = (state_reg == ST_REMOVE);
    assign ctl.insert = (state_reg == ST_INSERT);
    assign ctl.clear  = 1'b0;

    genvar g;
    generate
        for (g = 0; g < MAX_WINDOW; g++) begin : g_row
            logic [SW-1:0] lv, rv;
            logic lm, lg, occ;
            if (g == 0) begin : g_first
                assign lv = '0;
                assign lm = 1'b0;
                assign lg = 1'b0;
            end else begin : g_mid
                assign lv = vals[g-1];
                assign lm = match[g-1];
                assign lg = gts[g-1];
            end
            if (g == MAX_WINDOW - 1) begin : g_last
                assign rv = '0;
            end else begin : g_nrm
                assign rv = vals[g+1];
            end
            assign occ = (g < fill_reg);
            smad_cell #(.SW(SW)) u_cell (
                .aclk(aclk), .ctl(ctl), .key(key),
                .left_val(lv), .left_match(lm), .left_gt(lg),
                .right_val(rv), .occupied(occ),
                .val(vals[g]), .match_out(match[g]), .gt_out(gts[g])
            );
        end
    endgenerate

    // fill_reg counts occupied cells; during remove it drops by one
    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        ptr_next   = ptr_reg;
        idx_next   = idx_reg;
        acc_next   = acc_reg;
        done       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    state_next = (fill_reg == k_eff) ? ST_REMOVE : ST_INSERT;
                end
            end
            ST_REMOVE: begin
                fill_next  = fill_reg - CW'(1);
                state_next = ST_INSERT;
            end
            ST_INSERT: begin
                fill_next = fill_reg + CW'(1);
                ptr_next  = ({1'b0, ptr_reg} + 1'b1 >= k_eff) ? '0 : ptr_reg + AW'(1);
                idx_next  = '0;
                acc_next  = '0;
                state_next = (fill_reg + CW'(1) == k_eff) ? ST_SUM : ST_IDLE;
            end
            ST_SUM: begin
                if (idx_reg == k_eff) begin
                    if (!out_valid_reg || m_axis_tready) begin
                        done = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else begin
                    if (idx_reg < half) acc_next = acc_reg - COST_W'(cur);
                    else acc_next = acc_reg + COST_W'(cur);
                    if ((idx_reg == half - CW'(1)) && k_eff[0])
                        acc_next = acc_reg;
                    idx_next = idx_reg + CW'(1);
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign cur = vals[idx_reg[AW-1:0]];

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            sample_reg <= in_s;
            old_reg    <= ring[ptr_reg];
            ring[ptr_reg] <= in_s;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            wsize_reg <= WINDOW_RESET;
            fill_reg  <= '0;
            ptr_reg   <= '0;
            idx_reg   <= '0;
            acc_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            ptr_reg   <= ptr_next;
            idx_reg   <= idx_next;
            acc_reg   <= acc_next;
            if (cfg_tvalid && cfg_tready) begin
                wsize_reg <= cfg_tdata[KW-1:0];
                fill_reg  <= '0;
                ptr_reg   <= '0;
            end
            if (done) out_valid_reg <= 1'b1;
            else if (m_axis_tready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (done) out_data_reg <= acc_reg;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_data_reg};
endmodule

// ----- rtl/smad_checker.sv -----
// ============================================================================
// smad_checker
// Port-level checks for the sliding median absolute deviation block.
// ============================================================================
module smad_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        cfg_tvalid,
    input logic        cfg_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed while stalled");
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[23:21] == 3'b000)
        else $error("padding bits set");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("accepted back to back");
    a_cfg: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_tvalid && cfg_tready |-> !(s_axis_tvalid && s_axis_tready))
        else $error("config and sample together");
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("valid after reset");
endmodule

bind sliding_median_abs_deviation smad_checker u_smad_checker (
    .aclk(aclk), .aresetn(aresetn),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .cfg_tvalid(cfg_tvalid), .cfg_tready(cfg_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding median absolute deviation testbench
// Streams samples through the block under several window sizes, predicts
// each window cost from a sorted copy of the window and checks every
// output transaction in order, with random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb;
    import smad_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        cfg_tvalid = 1'b0;
    logic        cfg_tready;
    logic [7:0]  cfg_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;

    sliding_median_abs_deviation dut (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // model state
    int unsigned      win_k = WINDOW_RESET;
    logic [15:0]      hist[64];
    logic [15:0]      sorted_q[$];
    int unsigned      fill_n = 0;
    int unsigned      oldest = 0;
    logic [20:0]      cost_q[$];
    bit               failed = 0;
    int               burst_left = 0;

    function automatic void set_window(logic [6:0] v);
        win_k = (v == 0) ? 1 : (v > 64 ? 64 : v);
        fill_n = 0;
        oldest = 0;
        sorted_q.delete();
    endfunction

    function automatic void predict_cost(logic [15:0] s);
        int unsigned half, i, pos;
        longint lo, hi;
        lo = 0;
        hi = 0;
        if (oldest >= win_k) oldest = 0;
        if (fill_n < win_k) begin
            fill_n++;
        end else begin
            for (i = 0; i < sorted_q.size(); i++) begin
                if (sorted_q[i] == hist[oldest]) begin
                    sorted_q.delete(i);
                    break;
                end
            end
        end
        pos = 0;
        while (pos < sorted_q.size() && sorted_q[pos] <= s) pos++;
        sorted_q.insert(pos, s);
        hist[oldest] = s;
        oldest = (oldest + 1) % win_k;
        if (fill_n < win_k) return;
        half = (win_k + 1) / 2;
        for (i = 0; i < win_k; i++) begin
            if (i < half) lo += sorted_q[i];
            else hi += sorted_q[i];
        end
        if (win_k % 2) hi += sorted_q[half - 1];
        cost_q.push_back(21'(hi - lo));
    endfunction

    task automatic send_sample(logic [15:0] s, bit paced);
        int gap;
        gap = 0;
        if (paced) begin
            if (burst_left == 0) begin
                gap = $urandom_range(0, 6);
                burst_left = $urandom_range(1, 20);
            end
            burst_left--;
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= s;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        predict_cost(s);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (cost_q.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic write_window(logic [6:0] v);
        drain();
        cfg_tvalid <= 1'b1;
        cfg_tdata  <= {1'b0, v};
        @(posedge aclk);
        while (!cfg_tready) @(posedge aclk);
        set_window(v);
        cfg_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    // receiver stall pattern
    int unsigned stall_mode = 0;
    always @(posedge aclk) begin
        if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            2: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= $urandom_range(0, 1);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (cost_q.size() == 0) begin
                $display("%0t: unexpected cost, expected none, actual %0d",
                         $time, m_axis_tdata[20:0]);
                failed = 1;
            end else begin
                if (m_axis_tdata[20:0] !== cost_q[0]) begin
                    $display("%0t: cost mismatch, expected %0d, actual %0d",
                             $time, cost_q[0], m_axis_tdata[20:0]);
                    failed = 1;
                end
                void'(cost_q.pop_front());
            end
        end
    end

    task automatic test_reset_window();
        int i;
        for (i = 0; i < 12; i++) send_sample(16'(i * 5000), 0);
        send_sample(16'hFFFF, 0);
        send_sample(16'h0000, 0);
        send_sample(16'hFFFF, 0);
        send_sample(16'hAAAA, 0);
        send_sample(16'h5555, 0);
    endtask

    task automatic test_window_extremes();
        int i;
        write_window(7'd1);
        for (i = 0; i < 4; i++) send_sample(16'($urandom), 0);
        write_window(7'd0);
        send_sample(16'hFFFF, 0);
        send_sample(16'h0000, 0);
        write_window(7'd127);
        for (i = 0; i < 70; i++) send_sample((i % 2) ? 16'hFFFF : 16'h0000, 1);
        write_window(7'd64);
        for (i = 0; i < 70; i++) send_sample(16'hFFFF, 1);
        write_window(7'd3);
        send_sample(16'd7, 0);
        send_sample(16'd7, 0);
        // window rewritten mid-fill
        write_window(7'd2);
        for (i = 0; i < 4; i++) send_sample(16'd7, 0);
    endtask

    task automatic test_random_windows();
        logic [6:0] sizes[8] = '{7'd2, 7'd5, 7'd8, 7'd16, 7'd33, 7'd64, 7'd4, 7'd7};
        int p, i, n;
        logic [15:0] s;
        for (p = 0; p < 8; p++) begin
            write_window(sizes[p]);
            n = (sizes[p] > 30) ? 100 : 130;
            for (i = 0; i < n; i++) begin
                case ($urandom_range(0, 3))
                    0: s = 16'($urandom_range(0, 7));
                    1: s = 16'($urandom_range(65528, 65535));
                    default: s = 16'($urandom);
                endcase
                send_sample(s, 1);
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_window();
        test_window_extremes();
        test_random_windows();
        drain();
        if (!failed) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end

    initial begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/smad_pkg.sv
rtl/smad_cell.sv
rtl/sliding_median_abs_deviation.sv
rtl/smad_checker.sv
test/tb.sv
